FILE: rtl/hpa_pkg.sv
`default_nettype none
package hpa_pkg;

  typedef struct packed {
    logic [15:0] addend_a;
    logic [15:0] addend_b;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [15:0] sum;
    logic        last_out;
  } out_t;

  localparam logic [15:0] INF16 = 16'h7c00;

endpackage
`default_nettype wire

FILE: rtl/half_precision_adder.sv
`default_nettype none
// channel  | dir | ports                          | payload
// input    | in  | in_valid, in_stall, in_data    | hpa_pkg::in_t
// result   | out | out_valid, out_stall, out_data | hpa_pkg::out_t
// four register stages: operand decode and fixed-point add, magnitude and
// leading-zero count, normalize and round to 24 bits, round to 11 bits and pack.
// one transaction per cycle unless stalled; valid runs v1_r->v2_r->v3_r->out_valid.
// rst_n clears the stage valid bits only.
// a stall with out_valid high freezes every stage at once; in_stall follows it.
module half_precision_adder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hpa_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hpa_pkg::out_t      out_data
);

  function automatic logic signed [41:0] to_units(input logic [15:0] h);
    logic [41:0] mag;
    begin
      if (h[14:10] == 5'd0) begin
        mag = {32'd0, h[9:0]};
      end else begin
        mag = {31'd0, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
      end
      to_units = h[15] ? -$signed(mag) : $signed(mag);
    end
  endfunction

  function automatic logic [5:0] lzc42(input logic [41:0] v);
    logic [5:0] n;
    logic       found;
    begin
      n = 6'd42;
      found = 1'b0;
      for (int i = 41; i >= 0; i--) begin
        if (v[i] && !found) begin
          n = 6'(41 - i);
          found = 1'b1;
        end
      end
      lzc42 = n;
    end
  endfunction

  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage 1
  logic               v1_r, last1_r, spec1_r, zs1_r;
  logic [15:0]        sv1_r;
  logic signed [41:0] s1_r;
  logic               spec1_nxt;
  logic [15:0]        sv1_nxt;
  logic               nan_a, nan_b, inf_a, inf_b;

  always_comb begin
    nan_a = (in_data.addend_a[14:10] == 5'h1f) && (in_data.addend_a[9:0] != 10'd0);
    nan_b = (in_data.addend_b[14:10] == 5'h1f) && (in_data.addend_b[9:0] != 10'd0);
    inf_a = (in_data.addend_a[14:10] == 5'h1f) && (in_data.addend_a[9:0] == 10'd0);
    inf_b = (in_data.addend_b[14:10] == 5'h1f) && (in_data.addend_b[9:0] == 10'd0);
    spec1_nxt = 1'b1;
    sv1_nxt   = in_data.addend_a;
    if (nan_a) begin
      sv1_nxt = {in_data.addend_a[15], 15'd0} | hpa_pkg::INF16;
    end else if (nan_b) begin
      sv1_nxt = {in_data.addend_b[15], 15'd0} | hpa_pkg::INF16;
    end else if (inf_a && inf_b) begin
      // opposite infinities give plus infinity
      sv1_nxt = (in_data.addend_a[15] ^ in_data.addend_b[15]) ? hpa_pkg::INF16
                                                              : in_data.addend_a;
    end else if (inf_a) begin
      sv1_nxt = in_data.addend_a;
    end else if (inf_b) begin
      sv1_nxt = in_data.addend_b;
    end else begin
      spec1_nxt = 1'b0;
    end
  end

  // stage 2
  logic        v2_r, last2_r, spec2_r, sg2_r;
  logic [15:0] sv2_r;
  logic [41:0] m2_r;
  logic [5:0]  lz2_r;
  logic [41:0] mag1;

  assign mag1 = s1_r[41] ? 42'(-s1_r) : 42'(s1_r);

  // stage 3
  logic        v3_r, last3_r, spec3_r, sg3_r;
  logic [15:0] sv3_r;
  logic [23:0] r3_r;
  logic [6:0]  len3_r;
  logic [41:0] x2;
  logic        inc1;
  logic [24:0] q1;

  always_comb begin
    x2   = m2_r << lz2_r;
    inc1 = x2[17] && ((|x2[16:0]) || x2[18]);
    q1   = {1'b0, x2[41:18]} + 25'(inc1);
  end

  // stage 4 / output
  logic        inc2, c2;
  logic [11:0] q2;
  logic [10:0] mant;
  logic [6:0]  lf;
  logic [15:0] bits;

  always_comb begin
    inc2 = r3_r[12] && ((|r3_r[11:0]) || r3_r[13]);
    q2   = {1'b0, r3_r[23:13]} + 12'(inc2);
    c2   = q2[11];
    mant = c2 ? 11'h400 : q2[10:0];
    lf   = len3_r + 7'(c2);
    if (lf <= 7'd10) begin
      bits = {5'd0, mant >> (4'd11 - lf[3:0])};
    end else if (lf >= 7'd41) begin
      bits = hpa_pkg::INF16;
    end else begin
      bits = {1'b0, 5'(lf - 7'd10), mant[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last1_r <= in_data.last_in;
      spec1_r <= spec1_nxt;
      sv1_r   <= sv1_nxt;
      zs1_r   <= in_data.addend_a[15] & in_data.addend_b[15];
      s1_r    <= to_units(in_data.addend_a) + to_units(in_data.addend_b);

      last2_r <= last1_r;
      // exact zero sum
      spec2_r <= spec1_r || (s1_r == 42'sd0);
      sv2_r   <= spec1_r ? sv1_r : {zs1_r, 15'd0};
      sg2_r   <= s1_r[41];
      m2_r    <= mag1;
      lz2_r   <= lzc42(mag1);

      last3_r <= last2_r;
      spec3_r <= spec2_r;
      sv3_r   <= sv2_r;
      sg3_r   <= sg2_r;
      r3_r    <= q1[24] ? 24'h800000 : q1[23:0];
      len3_r  <= 7'd42 - {1'b0, lz2_r} + 7'(q1[24]);

      out_data.last_out <= last3_r;
      out_data.sum      <= spec3_r ? sv3_r : ({sg3_r, 15'd0} | bits);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hpa_chk.sv
`default_nettype none
module hpa_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire hpa_pkg::out_t out_data
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

endmodule

bind half_precision_adder hpa_chk u_hpa_chk (.*);
`default_nettype wire
